// ===== rtl/ipv4p_pkg.sv =====
// Shared types and constants for the dotted IPv4 address parser.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package ipv4p_pkg;

	// Width of one input character
	localparam int unsigned CharW = 8;
	// Width of the assembled address
	localparam int unsigned AddrW = 32;
	// Number of finished parts that are kept before the current one
	localparam int unsigned SavedParts = 3;
	// Bits kept of each finished part; assembly never looks higher
	localparam int unsigned SavedW = 24;

	// Largest last part for the a.b, a.b.c and a.b.c.d forms
	localparam logic [AddrW-1:0] Lim24 = 32'h00ff_ffff;
	localparam logic [AddrW-1:0] Lim16 = 32'h0000_ffff;
	localparam logic [AddrW-1:0] Lim8  = 32'h0000_00ff;

	// Where the parser stands inside the string
	typedef enum logic [1:0] {
		PH_START = 2'd0,  // expecting the first digit of a part
		PH_ZERO  = 2'd1,  // just after a leading zero
		PH_DIGIT = 2'd2,  // inside the digits of a part
		PH_SKIP  = 2'd3   // verdict given, waiting for the last character
	} phase_t;

	// Number base of the current part
	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	// One result item
	typedef struct packed {
		logic             ok;
		logic [AddrW-1:0] address;
	} verdict_t;

endpackage

`default_nettype wire

// ===== rtl/ipv4p_core.sv =====
// Parser state registers and the per-character update logic.
// Depends on ipv4p_pkg for the phase, radix and verdict types.
`default_nettype none

module ipv4p_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire logic [ipv4p_pkg::CharW-1:0]  ch,
	input  wire logic                         last,
	output logic                              needs_result,
	output ipv4p_pkg::verdict_t               verdict
);

	ipv4p_pkg::phase_t                                          phase_q, phase_d;
	ipv4p_pkg::radix_t                                          radix_q, radix_d;
	logic [ipv4p_pkg::AddrW-1:0]                                part_value_q, part_value_d;
	logic [ipv4p_pkg::SavedParts-1:0][ipv4p_pkg::SavedW-1:0]    saved_parts_q, saved_parts_d;
	logic [1:0]                                                 part_count_q, part_count_d;

	// Assemble the address from the finished parts and the current part
	function automatic ipv4p_pkg::verdict_t finish_addr(
		input ipv4p_pkg::phase_t                                       ph,
		input logic [1:0]                                              pc,
		input logic [ipv4p_pkg::AddrW-1:0]                             pv,
		input logic [ipv4p_pkg::SavedParts-1:0][ipv4p_pkg::SavedW-1:0] sp
	);
		ipv4p_pkg::verdict_t r;
		r.ok      = 1'b1;
		r.address = pv;
		if (ph == ipv4p_pkg::PH_START) begin
			r.ok = 1'b0;
		end else begin
			case (pc)
				2'd1: begin
					r.ok      = (pv <= ipv4p_pkg::Lim24);
					r.address = {sp[0][7:0], pv[23:0]};
				end
				2'd2: begin
					r.ok      = (pv <= ipv4p_pkg::Lim16);
					r.address = {sp[0][7:0], 24'h0} | {sp[1][15:0], 16'h0} | pv;
				end
				2'd3: begin
					r.ok      = (pv <= ipv4p_pkg::Lim8);
					r.address = {sp[0][7:0], 24'h0} | {sp[1][15:0], 16'h0}
						| {sp[2], 8'h0} | pv;
				end
				default: begin
					r.address = pv;
				end
			endcase
		end
		if (!r.ok) begin
			r.address = '0;
		end
		return r;
	endfunction

	// Work out the next state and any verdict for the character at hand
	always_comb begin
		ipv4p_pkg::phase_t                                       ph;
		ipv4p_pkg::radix_t                                       rx;
		logic [ipv4p_pkg::AddrW-1:0]                             pv;
		logic [ipv4p_pkg::SavedParts-1:0][ipv4p_pkg::SavedW-1:0] sp;
		logic [1:0]                                              pc;
		logic                                                    pending;
		logic                                                    took_x;
		logic                                                    is_dig;
		logic                                                    is_hexl;
		logic                                                    is_term;
		ipv4p_pkg::verdict_t                                     v;

		ph      = phase_q;
		rx      = radix_q;
		pv      = part_value_q;
		sp      = saved_parts_q;
		pc      = part_count_q;
		pending = 1'b1;
		took_x  = 1'b0;
		v       = '0;
		is_dig  = ch inside {["0":"9"]};
		is_hexl = ch inside {["a":"f"], ["A":"F"]};
		is_term = ch inside {8'd0, 8'd32, [8'd9:8'd13]};
		needs_result = 1'b0;

		if (phase_q == ipv4p_pkg::PH_SKIP) begin
			pending = 1'b0;
		end else if (phase_q == ipv4p_pkg::PH_START) begin
			if (is_dig) begin
				pv = {{(ipv4p_pkg::AddrW-4){1'b0}}, ch[3:0]};
				rx = ipv4p_pkg::RX_DEC;
				ph = (ch == "0") ? ipv4p_pkg::PH_ZERO : ipv4p_pkg::PH_DIGIT;
			end else begin
				pending = 1'b0;
				needs_result = 1'b1;
			end
		end else begin
			// Resolve the radix after a leading zero
			if (phase_q == ipv4p_pkg::PH_ZERO) begin
				ph = ipv4p_pkg::PH_DIGIT;
				if (ch == "x" || ch == "X") begin
					rx     = ipv4p_pkg::RX_HEX;
					took_x = 1'b1;
				end else begin
					rx = ipv4p_pkg::RX_OCT;
				end
			end
			if (!took_x) begin
				if (is_dig) begin
					case (rx)
						ipv4p_pkg::RX_HEX: pv = {pv[27:0], 4'd0};
						ipv4p_pkg::RX_OCT: pv = {pv[28:0], 3'd0};
						default:           pv = {pv[28:0], 3'd0} + {pv[30:0], 1'b0};
					endcase
					pv = pv + {{(ipv4p_pkg::AddrW-4){1'b0}}, ch[3:0]};
				end else if (rx == ipv4p_pkg::RX_HEX && is_hexl) begin
					pv = {pv[27:0], ch[3:0] + 4'd9};
				end else if (ch == ".") begin
					if (pc == 2'd3) begin
						pending = 1'b0;
						needs_result = 1'b1;
					end else begin
						sp[pc] = pv[ipv4p_pkg::SavedW-1:0];
						pc     = pc + 2'd1;
						pv     = '0;
						rx     = ipv4p_pkg::RX_DEC;
						ph     = ipv4p_pkg::PH_START;
					end
				end else if (is_term) begin
					pending = 1'b0;
					needs_result = 1'b1;
					v = finish_addr(ph, pc, pv, sp);
				end else begin
					pending = 1'b0;
					needs_result = 1'b1;
				end
			end
		end

		// String end closes the address
		if (pending && last) begin
			needs_result = 1'b1;
			v = finish_addr(ph, pc, pv, sp);
		end

		if (needs_result) begin
			ph = ipv4p_pkg::PH_SKIP;
		end
		// Re-arm at the last character
		if (last) begin
			ph = ipv4p_pkg::PH_START;
			rx = ipv4p_pkg::RX_DEC;
			pv = '0;
			sp = '0;
			pc = 2'd0;
		end

		phase_d       = ph;
		radix_d       = rx;
		part_value_d  = pv;
		saved_parts_d = sp;
		part_count_d  = pc;
		verdict       = v;
	end

	// Hold state between characters, advance on fire
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= ipv4p_pkg::PH_START;
			radix_q       <= ipv4p_pkg::RX_DEC;
			part_value_q  <= '0;
			saved_parts_q <= '0;
			part_count_q  <= 2'd0;
		end else if (fire) begin
			phase_q       <= phase_d;
			radix_q       <= radix_d;
			part_value_q  <= part_value_d;
			saved_parts_q <= saved_parts_d;
			part_count_q  <= part_count_d;
		end
	end

	// The skip phase never yields a verdict
	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == ipv4p_pkg::PH_SKIP) |-> !needs_result)
		else $error("verdict produced while skipping");

	// The last character always re-arms the parser
	a_last_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && last) |=> (phase_q == ipv4p_pkg::PH_START && part_count_q == 2'd0))
		else $error("parser not re-armed after last character");

	// A failed verdict carries a zero address
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(needs_result && !verdict.ok) |-> (verdict.address == '0))
		else $error("nonzero address on failed verdict");

endmodule

`default_nettype wire

// ===== rtl/ipv4p_out_reg.sv =====
// Result register for the parser's output channel (valid/stall).
// Depends on ipv4p_pkg for the verdict type.
`default_nettype none

module ipv4p_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire ipv4p_pkg::verdict_t  verdict,
	output logic                      free,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic                      ok,
	output logic [ipv4p_pkg::AddrW-1:0] address
);

	logic                valid_q;
	ipv4p_pkg::verdict_t data_q;

	// Slot is free when empty or being taken this cycle
	assign free = !valid_q || !result_stall;

	// Track occupancy of the result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the verdict
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= verdict;
		end
	end

	assign result_valid = valid_q;
	assign ok           = data_q.ok;
	assign address      = data_q.address;

	// Never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !(valid_q && result_stall))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/ipv4_dotted_address_parser.sv =====
// Path: an accepted character is registered in the input register, and its verdict
// is then loaded into the result register, which drives result_valid; a result
// still stalled in that register holds the character back in the input register.
// Throughput: one character per cycle; the per-character shift-add part update
// is the state loop that sets it. A waiting result stalls only a verdict.
// Reset: arst_n clears the parser state and both valid flags asynchronously.
`default_nettype none

module ipv4_dotted_address_parser (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire logic [ipv4p_pkg::CharW-1:0]   ch,
	input  wire logic                          last,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               ok,
	output logic [ipv4p_pkg::AddrW-1:0]        address
);

	logic                         s1_valid_q;
	logic [ipv4p_pkg::CharW-1:0]  ch_s1;
	logic                         last_s1;
	logic                         accept;
	logic                         advance;
	logic                         needs_result;
	logic                         out_free;
	ipv4p_pkg::verdict_t          verdict;

	// Advance the registered character unless its verdict has nowhere to go
	assign advance    = s1_valid_q && (!needs_result || out_free);
	assign char_stall = s1_valid_q && !advance;
	assign accept     = char_valid && !char_stall;

	// Input register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Capture the request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
	end

	ipv4p_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.ch           (ch_s1),
		.last         (last_s1),
		.needs_result (needs_result),
		.verdict      (verdict)
	);

	ipv4p_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && needs_result),
		.verdict      (verdict),
		.free         (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ok           (ok),
		.address      (address)
	);

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for ipv4_dotted_address_parser: drives address strings one character
// per request and checks each verdict against a cycle-free predictor of the parsing rules.
// Depends on ipv4p_pkg for the phase, radix and verdict types and the range limits.
`timescale 1ns / 1ps

module testbench;

	// ASCII codes the parser gives meaning to
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_TOP   = 8'hff;

	localparam int PHASES = 4;
	localparam int CHARS_PER_PHASE = 112;

	typedef enum logic [1:0] {SCAN_PENDING, SCAN_BAD, SCAN_GOOD} scan_t;

	typedef struct {
		logic [7:0] ch;
		logic       lst;
	} char_req_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            char_valid = 1'b0;
	logic                            char_stall;
	logic [ipv4p_pkg::CharW-1:0]     ch = '0;
	logic                            last = 1'b0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	logic                            ok;
	logic [ipv4p_pkg::AddrW-1:0]     address;

	// Parser state mirrored by the predictor
	ipv4p_pkg::phase_t prs_phase;
	ipv4p_pkg::radix_t prs_radix;
	logic [31:0]       prs_value;
	logic [23:0]       prs_saved [ipv4p_pkg::SavedParts];
	logic [1:0]        prs_count;

	char_req_t             pending_chars [$];
	ipv4p_pkg::verdict_t   expected_verdicts [$];
	logic [7:0]            text [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int chars_queued = 0;
	int chars_accepted = 0;
	int strings_queued = 0;
	int verdicts_checked = 0;
	int addresses_ok = 0;

	ipv4_dotted_address_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.ch           (ch),
		.last         (last),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ok           (ok),
		.address      (address)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Clear the parser state for a new string
	function automatic void rearm();
		prs_phase = ipv4p_pkg::PH_START;
		prs_radix = ipv4p_pkg::RX_DEC;
		prs_value = '0;
		for (int i = 0; i < ipv4p_pkg::SavedParts; i++) prs_saved[i] = '0;
		prs_count = '0;
	endfunction

	function automatic bit is_terminator(logic [7:0] c);
		return c == CH_NUL || c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	// Assemble a, a.b, a.b.c or a.b.c.d; only the last part is range checked
	function automatic scan_t assemble(output logic [31:0] addr);
		logic [31:0] v;
		v = prs_value;
		addr = '0;
		if (prs_phase == ipv4p_pkg::PH_START) return SCAN_BAD;
		case (prs_count)
			2'd1: begin
				if (v > ipv4p_pkg::Lim24) return SCAN_BAD;
				v = v | {prs_saved[0][7:0], 24'h0};
			end
			2'd2: begin
				if (v > ipv4p_pkg::Lim16) return SCAN_BAD;
				v = v | {prs_saved[0][7:0], 24'h0} | {prs_saved[1][15:0], 16'h0};
			end
			2'd3: begin
				if (v > ipv4p_pkg::Lim8) return SCAN_BAD;
				v = v | {prs_saved[0][7:0], 24'h0} | {prs_saved[1][15:0], 16'h0}
					| {prs_saved[2], 8'h0};
			end
			default: ;
		endcase
		addr = v;
		return SCAN_GOOD;
	endfunction

	// Advance the parser by one character outside the skip phase
	function automatic scan_t scan_char(logic [7:0] c, output logic [31:0] addr);
		addr = '0;
		if (prs_phase == ipv4p_pkg::PH_START) begin
			if (c < CH_ZERO || c > CH_NINE) return SCAN_BAD;
			prs_value = {24'h0, c - CH_ZERO};
			prs_radix = ipv4p_pkg::RX_DEC;
			prs_phase = (c == CH_ZERO) ? ipv4p_pkg::PH_ZERO : ipv4p_pkg::PH_DIGIT;
			return SCAN_PENDING;
		end
		if (prs_phase == ipv4p_pkg::PH_ZERO) begin
			prs_phase = ipv4p_pkg::PH_DIGIT;
			if (c == CH_LX || c == CH_UX) begin
				prs_radix = ipv4p_pkg::RX_HEX;
				return SCAN_PENDING;
			end
			prs_radix = ipv4p_pkg::RX_OCT;
		end
		if (c >= CH_ZERO && c <= CH_NINE) begin
			case (prs_radix)
				ipv4p_pkg::RX_HEX: prs_value = prs_value * 16 + {24'h0, c - CH_ZERO};
				ipv4p_pkg::RX_OCT: prs_value = prs_value * 8 + {24'h0, c - CH_ZERO};
				default:           prs_value = prs_value * 10 + {24'h0, c - CH_ZERO};
			endcase
			return SCAN_PENDING;
		end
		if (prs_radix == ipv4p_pkg::RX_HEX && c >= CH_LA && c <= CH_LF) begin
			prs_value = (prs_value << 4) | {24'h0, c - CH_LA + 8'd10};
			return SCAN_PENDING;
		end
		if (prs_radix == ipv4p_pkg::RX_HEX && c >= CH_UA && c <= CH_UF) begin
			prs_value = (prs_value << 4) | {24'h0, c - CH_UA + 8'd10};
			return SCAN_PENDING;
		end
		if (c == CH_DOT) begin
			if (prs_count >= 2'd3) return SCAN_BAD;
			prs_saved[prs_count] = prs_value[23:0];
			prs_count = prs_count + 2'd1;
			prs_value = '0;
			prs_radix = ipv4p_pkg::RX_DEC;
			prs_phase = ipv4p_pkg::PH_START;
			return SCAN_PENDING;
		end
		if (is_terminator(c)) return assemble(addr);
		return SCAN_BAD;
	endfunction

	// Predict the verdict, if any, that one accepted character causes
	function automatic bit predict_verdict(logic [7:0] c, logic lst,
		output ipv4p_pkg::verdict_t res);
		scan_t       s;
		logic [31:0] addr;
		res = '0;
		if (prs_phase == ipv4p_pkg::PH_SKIP) begin
			if (lst) rearm();
			return 1'b0;
		end
		s = scan_char(c, addr);
		if (s == SCAN_PENDING && lst) s = assemble(addr);
		if (s == SCAN_PENDING) return 1'b0;
		res.ok = (s == SCAN_GOOD);
		res.address = (s == SCAN_GOOD) ? addr : '0;
		if (lst) rearm();
		else prs_phase = ipv4p_pkg::PH_SKIP;
		return 1'b1;
	endfunction

	// Drive character requests; predict at each accepted one
	always @(posedge clk) begin : drive_chars
		ipv4p_pkg::verdict_t res;
		char_req_t           req;
		if (!arst_n) begin
			rearm();
		end else begin
			if (char_valid && !char_stall) begin
				chars_accepted++;
				if (predict_verdict(ch, last, res)) expected_verdicts.push_back(res);
			end
			if (!char_valid || !char_stall) begin
				if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req = pending_chars.pop_front();
					char_valid <= 1'b1;
					ch <= req.ch;
					last <= req.lst;
				end else begin
					char_valid <= 1'b0;
				end
			end
		end
	end

	// Check each accepted verdict against the oldest prediction; stall at random
	always @(posedge clk) begin : check_verdicts
		ipv4p_pkg::verdict_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected verdict: ok=%0b address=%h", ok, address);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					verdicts_checked++;
					if (want.ok) addresses_ok++;
					if (ok !== want.ok) begin
						$error("ok: expected %0b, got %0b", want.ok, ok);
						errors++;
					end
					if (address !== want.address) begin
						$error("address: expected %h, got %h", want.address, address);
						errors++;
					end
				end
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	task automatic push_char(logic [7:0] c, logic lst);
		char_req_t req;
		req.ch = c;
		req.lst = lst;
		pending_chars.push_back(req);
		chars_queued++;
	endtask

	// Queue the text buffer as one string, last flag on its final character
	task automatic queue_text();
		for (int i = 0; i < text.size(); i++) push_char(text[i], i == text.size() - 1);
		strings_queued++;
	endtask

	task automatic load_text(string s);
		text.delete();
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
	endtask

	// Append one part: decimal, wide decimal, octal (8 and 9 included) or hex
	task automatic add_part();
		int         kind;
		int         n;
		int         d;
		string      s;
		kind = $urandom_range(0, 9);
		s = "";
		case (kind)
			0, 1, 2, 3: s = $sformatf("%0d", $urandom_range(0, 255));
			4:          s = $sformatf("%0d", $urandom);
			5:          s = $sformatf("%0d%0d", $urandom_range(1, 9), $urandom);
			6, 7: begin
				text.push_back(CH_ZERO);
				n = $urandom_range(0, 5);
				repeat (n) text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			default: begin
				text.push_back(CH_ZERO);
				text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
				n = $urandom_range(0, 9);
				repeat (n) begin
					d = $urandom_range(0, 15);
					if (d < 10) text.push_back(CH_ZERO + 8'(d));
					else text.push_back(($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(d - 10));
				end
			end
		endcase
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
	endtask

	// Build one random string: mostly well formed, some broken, some noise
	task automatic make_string();
		int k;
		int t;
		int nparts;
		int empty_at;
		text.delete();
		k = $urandom_range(0, 99);
		if (k < 10) begin
			repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		nparts = (k < 15) ? 5 : $urandom_range(1, 4);
		empty_at = (k >= 15 && k < 20) ? $urandom_range(0, nparts - 1) : -1;
		for (int p = 0; p < nparts; p++) begin
			if (p != 0) text.push_back(CH_DOT);
			if (p != empty_at) add_part();
		end
		// corrupt one character
		if (k >= 20 && k < 30)
			text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
		t = $urandom_range(0, 9);
		if (t >= 5) begin
			case (t)
				5:       text.push_back(CH_NUL);
				6:       text.push_back(CH_SPACE);
				default: text.push_back(8'($urandom_range(CH_TAB, CH_CR)));
			endcase
			repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// Hold the sender until every prediction has been matched
	task automatic drain();
		while (pending_chars.size() != 0 || char_valid || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin : reset_gen
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin : stimulus
		int idle_plan [PHASES];
		int stall_plan [PHASES];
		int target;
		idle_plan = '{0, 50, 0, 28};
		stall_plan = '{0, 0, 50, 28};
		while (!arst_n) @(posedge clk);

		// Directed: single digit, NUL and non-ASCII at part start, bare hex prefix,
		// fifth part, octal plus mixed-case hex with whitespace end and skipped tail
		load_text("0");
		queue_text();
		push_char(CH_NUL, 1'b1);
		push_char(CH_TOP, 1'b1);
		strings_queued += 2;
		load_text("0x");
		queue_text();
		load_text("1.2.3.4.");
		queue_text();
		load_text("07.0XaF 9");
		queue_text();
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = idle_plan[ph];
			stall_pct = stall_plan[ph];
			target = chars_queued + CHARS_PER_PHASE;
			while (chars_queued < target) begin
				make_string();
				queue_text();
			end
			drain();
		end
		stall_pct = 0;
		repeat (10) @(posedge clk);

		$display("Covered %0d strings, %0d characters accepted, %0d verdicts checked",
			strings_queued, chars_accepted, verdicts_checked);
		$display("(%0d valid addresses) under four idle and stall mixes", addresses_ok);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
